[rtl/core/assert_macros.svh]
// Assertion macros for the Laurent polynomial evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on i_clk and held off while i_rst_n is low.
`define CLH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and held off while i_rst_n is low.
`define CLH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/clh_pkg.sv]
// Types, constants and helper functions of the Laurent polynomial evaluator.
package clh_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 24;
    localparam int PWR_W     = 5;
    localparam int TERMS_DEF = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int RND_W     = PROD_W - FRAC_W;
    localparam int ACC_W     = 44;
    localparam int NUM_W     = DATA_W + 2 * FRAC_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic       REQ_LOAD = 1'b0;
    localparam logic       REQ_EVAL = 1'b1;
    localparam logic       CFG_LOW  = 1'b0;
    localparam logic       CFG_HIGH = 1'b1;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_POLE  = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_RD, S_ADD, S_M0, S_M1, S_M2, S_M3, S_M4, S_SAT,
        S_PEND, S_SQ0, S_SQ1, S_SQ2, S_DIV_RE, S_DIV_IM, S_SUM_RD, S_SUM, S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic neg;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic clamp;
    } t_div_stat;

    // Clamp a wide signed value to the data range.
    function automatic logic signed [DATA_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
        logic upper_same;
        upper_same = (&v[ACC_W-1:DATA_W-1]) | ~(|v[ACC_W-1:DATA_W-1]);
        if (upper_same) begin
            return v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // True when sat_val would have to clamp.
    function automatic logic sat_hit(input logic signed [ACC_W-1:0] v);
        return ~((&v[ACC_W-1:DATA_W-1]) | ~(|v[ACC_W-1:DATA_W-1]));
    endfunction

endpackage

[rtl/core/clh_coef_mem.sv]
// Coefficient table: one write port, one registered read port.
module clh_coef_mem #(
    parameter int TERMS = clh_pkg::TERMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(TERMS)-1:0]          i_waddr,
    input  logic signed [clh_pkg::DATA_W-1:0] i_wdata,
    input  logic [$clog2(TERMS)-1:0]          i_raddr,
    output logic signed [clh_pkg::DATA_W-1:0] o_rdata
);

    logic signed [clh_pkg::DATA_W-1:0] r_mem [TERMS];
    logic signed [clh_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/clh_mul.sv]
// Shared signed multiplier with a registered product and Q8.24 rounding.
module clh_mul (
    input  logic                              i_clk,
    input  logic signed [clh_pkg::DATA_W-1:0] i_a,
    input  logic signed [clh_pkg::DATA_W-1:0] i_b,
    output logic signed [clh_pkg::PROD_W-1:0] o_prod,
    output logic signed [clh_pkg::RND_W-1:0]  o_round
);

    localparam logic signed [clh_pkg::PROD_W-1:0] HALF =
        clh_pkg::PROD_W'(1) << (clh_pkg::FRAC_W - 1);

    logic signed [clh_pkg::PROD_W-1:0] r_prod;
    logic signed [clh_pkg::PROD_W-1:0] rnd_sum;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Add half an LSB and floor.
    assign rnd_sum = r_prod + HALF;
    assign o_prod  = r_prod;
    assign o_round = rnd_sum[clh_pkg::PROD_W-1:clh_pkg::FRAC_W];

endmodule

[rtl/core/clh_recip.sv]
// Bit-serial restoring divider forming one saturated part of 1/x.
module clh_recip (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  clh_pkg::t_div_req                 i_req,
    input  logic [clh_pkg::DATA_W-1:0]        i_num,
    input  logic [clh_pkg::PROD_W-1:0]        i_den,
    output clh_pkg::t_div_stat                o_stat,
    output logic signed [clh_pkg::DATA_W-1:0] o_value
);

    localparam int DW = clh_pkg::DATA_W;

    logic                        r_busy;
    logic                        r_done;
    logic [clh_pkg::DCNT_W-1:0]  r_cnt;
    logic [clh_pkg::NUM_W-1:0]   r_sh;
    logic [clh_pkg::PROD_W-1:0]  r_rem;
    logic [clh_pkg::PROD_W-1:0]  r_den;
    logic [DW:0]                 r_q;
    logic                        r_ovf;
    logic                        r_neg;
    logic [clh_pkg::PROD_W-1:0]  rem_sh;
    logic                        ge;
    logic                        big;
    logic                        at_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The remainder stays below the divisor, so its top bit is always clear.
    assign rem_sh = {r_rem[clh_pkg::PROD_W-2:0], r_sh[clh_pkg::NUM_W-1]};
    assign ge     = rem_sh >= r_den;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= clh_pkg::DCNT_W'(clh_pkg::DIV_STEPS - 1);
            r_sh  <= {i_num, {(2 * clh_pkg::FRAC_W){1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_neg <= i_req.neg;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_sh  <= r_sh << 1;
            r_rem <= ge ? rem_sh - r_den : rem_sh;
            r_q   <= {r_q[DW-1:0], ge};
            r_ovf <= r_ovf | r_q[DW];
        end
    end

    assign big    = r_ovf | r_q[DW] | (r_q[DW-1] & (|r_q[DW-2:0]));
    assign at_lim = r_q[DW-1] & ~(|r_q[DW-2:0]);

    always_comb begin
        o_stat.done  = r_done;
        o_stat.clamp = 1'b0;
        if (r_neg) begin
            if (big) begin
                o_value      = {1'b1, {(DW-1){1'b0}}};
                o_stat.clamp = 1'b1;
            end else begin
                o_value = -$signed(r_q[DW-1:0]);
            end
        end else begin
            if (big || at_lim) begin
                o_value      = {1'b0, {(DW-1){1'b1}}};
                o_stat.clamp = 1'b1;
            end else begin
                o_value = $signed(r_q[DW-1:0]);
            end
        end
    end

endmodule

[rtl/core/complex_laurent_horner_top.sv]
// Top level: complex Laurent polynomial evaluator, Horner's rule on shared units.
// A load beat is written to the table while the block stays idle and ready for the next beat.
// An evaluate beat walks each positive power in turn, then forms 1/x
// (two 80-step serial divisions) and walks each negative power when the low bound is below 0.
// One item is worked on at a time, set by the single multiplier and divider.
// i_rst_n is synchronous, active low: clears control and bounds; the coefficient table is not.
module complex_laurent_horner_top #(
    parameter int TERMS = clh_pkg::TERMS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Item channel. tdata from bit 0: coef_index[3:0], coef_value[31:0], x_re[31:0],
    // x_im[31:0], four zero bits.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [103:0] i_s_tdata,
    // tuser: req_type (0 load coefficient, 1 evaluate).
    input  logic         i_s_tuser,
    // Result channel. tdata from bit 0: result_re[31:0], result_im[31:0], status[1:0],
    // six zero bits.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [71:0]  o_m_tdata,
    // Configuration writes: index 0 is low_power, index 1 is high_power.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [4:0]   i_cfg_data
);

    `include "assert_macros.svh"

    localparam int DW = clh_pkg::DATA_W;
    localparam int AW = $clog2(TERMS);
    localparam int AC = clh_pkg::ACC_W;

    // Configuration registers.
    logic signed [clh_pkg::PWR_W-1:0] r_cfg_low;
    logic signed [clh_pkg::PWR_W-1:0] r_cfg_high;
    logic signed [clh_pkg::PWR_W-1:0] lo;
    logic signed [clh_pkg::PWR_W-1:0] hi;

    clh_pkg::t_state r_state;
    clh_pkg::t_state n_state;

    // Datapath registers.
    logic signed [DW-1:0]              r_xr, r_xi, r_vr, r_vi;
    logic signed [DW-1:0]              r_tr, r_ti, r_ar, r_ai, r_pr, r_pi;
    logic signed [AC-1:0]              r_acc_re, r_acc_im;
    logic [clh_pkg::PROD_W-1:0]        r_m;
    logic signed [clh_pkg::PWR_W-1:0]  r_p;
    logic                              r_neg;
    logic                              r_clamp;
    logic                              r_coef_ok;
    logic signed [DW-1:0]              r_fin_re, r_fin_im;
    logic [1:0]                        r_fin_st;
    logic                              r_out_valid;
    logic signed [DW-1:0]              r_out_re, r_out_im;
    logic [1:0]                        r_out_st;

    // Input fields.
    logic [3:0]           in_index;
    logic signed [DW-1:0] in_coef, in_xr, in_xi;
    logic                 s_acc;
    logic                 pole;
    logic                 out_free;

    // Shared units.
    logic signed [DW-1:0]             mul_a, mul_b;
    logic signed [clh_pkg::PROD_W-1:0] mul_prod;
    logic signed [clh_pkg::RND_W-1:0] mul_rnd;
    clh_pkg::t_div_req                div_req;
    clh_pkg::t_div_stat               div_stat;
    logic [DW-1:0]                    div_num;
    logic [clh_pkg::PROD_W-1:0]       div_den;
    logic signed [DW-1:0]             div_val;
    logic [DW-1:0]                    abs_xr, abs_xi;

    // Coefficient table access.
    logic                 mem_we;
    logic [AW-1:0]        mem_raddr;
    logic signed [DW-1:0] mem_rdata;
    logic signed [6:0]    slot;
    logic                 slot_ok;
    logic signed [DW-1:0] coef;
    logic signed [DW-1:0] a_re, a_im;
    logic signed [AC-1:0] add_sum, fin_sum_re, fin_sum_im;

    assign in_index = i_s_tdata[3:0];
    assign in_coef  = i_s_tdata[35:4];
    assign in_xr    = i_s_tdata[67:36];
    assign in_xi    = i_s_tdata[99:68];

    assign o_cfg_ready = 1'b1;
    assign lo = (r_cfg_low < r_cfg_high) ? r_cfg_low : r_cfg_high;
    assign hi = (r_cfg_low < r_cfg_high) ? r_cfg_high : r_cfg_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_low  <= '0;
            r_cfg_high <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                clh_pkg::CFG_LOW:  r_cfg_low  <= $signed(i_cfg_data);
                clh_pkg::CFG_HIGH: r_cfg_high <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign s_acc    = i_s_tvalid & o_s_tready;
    assign pole     = (lo < 0) && (r_xr == '0) && (r_xi == '0);
    assign out_free = !r_out_valid || i_m_tready;

    // Table slot of the current power; out-of-range powers read as zero.
    assign slot    = 7'(r_p) - 7'(lo);
    assign slot_ok = (r_p >= lo) && (r_p <= hi) && (32'(slot) < TERMS);
    assign mem_raddr = AW'(slot);
    assign mem_we  = s_acc && (i_s_tuser == clh_pkg::REQ_LOAD) && (32'(in_index) < TERMS);
    assign coef    = r_coef_ok ? mem_rdata : '0;

    assign a_re = r_neg ? r_vr : r_xr;
    assign a_im = r_neg ? r_vi : r_xi;
    assign abs_xr = r_xr[DW-1] ? DW'(-r_xr) : r_xr;
    assign abs_xi = r_xi[DW-1] ? DW'(-r_xi) : r_xi;

    assign add_sum    = AC'(coef) + AC'(r_ar);
    assign fin_sum_re = AC'(r_ar) + AC'(r_pr) + AC'(coef);
    assign fin_sum_im = AC'(r_ai) + AC'(r_pi);

    clh_coef_mem #(.TERMS(TERMS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(in_index)),
        .i_wdata (in_coef),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    clh_mul u_mul (
        .i_clk   (i_clk),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_round (mul_rnd)
    );

    clh_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_value (div_val)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            clh_pkg::S_IDLE: begin
                if (s_acc && i_s_tuser == clh_pkg::REQ_EVAL) n_state = clh_pkg::S_START;
            end
            clh_pkg::S_START: begin
                if (pole)         n_state = clh_pkg::S_OUT;
                else if (hi > 0)  n_state = clh_pkg::S_RD;
                else              n_state = clh_pkg::S_PEND;
            end
            clh_pkg::S_RD:  n_state = clh_pkg::S_ADD;
            clh_pkg::S_ADD: n_state = clh_pkg::S_M0;
            clh_pkg::S_M0:  n_state = clh_pkg::S_M1;
            clh_pkg::S_M1:  n_state = clh_pkg::S_M2;
            clh_pkg::S_M2:  n_state = clh_pkg::S_M3;
            clh_pkg::S_M3:  n_state = clh_pkg::S_M4;
            clh_pkg::S_M4:  n_state = clh_pkg::S_SAT;
            clh_pkg::S_SAT: begin
                if (!r_neg) n_state = (r_p > 5'sd1) ? clh_pkg::S_RD : clh_pkg::S_PEND;
                else        n_state = (r_p < -5'sd1) ? clh_pkg::S_RD : clh_pkg::S_SUM_RD;
            end
            clh_pkg::S_PEND: n_state = (lo < 0) ? clh_pkg::S_SQ0 : clh_pkg::S_SUM_RD;
            clh_pkg::S_SQ0:  n_state = clh_pkg::S_SQ1;
            clh_pkg::S_SQ1:  n_state = clh_pkg::S_SQ2;
            clh_pkg::S_SQ2:  n_state = clh_pkg::S_DIV_RE;
            clh_pkg::S_DIV_RE: begin
                if (div_stat.done) n_state = clh_pkg::S_DIV_IM;
            end
            clh_pkg::S_DIV_IM: begin
                if (div_stat.done) n_state = clh_pkg::S_RD;
            end
            clh_pkg::S_SUM_RD: n_state = clh_pkg::S_SUM;
            clh_pkg::S_SUM:    n_state = clh_pkg::S_OUT;
            clh_pkg::S_OUT: begin
                if (out_free) n_state = clh_pkg::S_IDLE;
            end
            default: n_state = clh_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: operand selection and divider requests.
    always_comb begin
        o_s_tready    = 1'b0;
        mul_a         = r_xr;
        mul_b         = r_xr;
        div_req.start = 1'b0;
        div_req.neg   = 1'b0;
        div_num       = abs_xr;
        div_den       = r_m;
        case (r_state)
            clh_pkg::S_IDLE: o_s_tready = 1'b1;
            clh_pkg::S_M0: begin
                mul_a = a_re;
                mul_b = r_tr;
            end
            clh_pkg::S_M1: begin
                mul_a = a_im;
                mul_b = r_ti;
            end
            clh_pkg::S_M2: begin
                mul_a = a_re;
                mul_b = r_ti;
            end
            clh_pkg::S_M3: begin
                mul_a = a_im;
                mul_b = r_tr;
            end
            clh_pkg::S_SQ1: begin
                mul_a = r_xi;
                mul_b = r_xi;
            end
            clh_pkg::S_SQ2: begin
                // |x|^2 completes here and goes straight into the divider.
                div_req.start = 1'b1;
                div_req.neg   = r_xr[DW-1];
                div_den       = r_m + $unsigned(mul_prod);
            end
            clh_pkg::S_DIV_RE: begin
                div_req.start = div_stat.done;
                div_req.neg   = ~r_xi[DW-1];
                div_num       = abs_xi;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clh_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == clh_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_coef_ok <= slot_ok;
        case (r_state)
            clh_pkg::S_IDLE: begin
                if (s_acc) begin
                    r_xr <= in_xr;
                    r_xi <= in_xi;
                end
            end
            clh_pkg::S_START: begin
                r_clamp  <= 1'b0;
                r_ar     <= '0;
                r_ai     <= '0;
                r_neg    <= 1'b0;
                r_p      <= hi;
                r_fin_re <= {1'b0, {(DW-1){1'b1}}};
                r_fin_im <= {1'b0, {(DW-1){1'b1}}};
                r_fin_st <= clh_pkg::ST_POLE;
            end
            clh_pkg::S_ADD: begin
                r_tr    <= clh_pkg::sat_val(add_sum);
                r_ti    <= r_ai;
                r_clamp <= r_clamp | clh_pkg::sat_hit(add_sum);
            end
            clh_pkg::S_M1: r_acc_re <= AC'(mul_rnd);
            clh_pkg::S_M2: r_acc_re <= r_acc_re - AC'(mul_rnd);
            clh_pkg::S_M3: r_acc_im <= AC'(mul_rnd);
            clh_pkg::S_M4: r_acc_im <= r_acc_im + AC'(mul_rnd);
            clh_pkg::S_SAT: begin
                r_ar    <= clh_pkg::sat_val(r_acc_re);
                r_ai    <= clh_pkg::sat_val(r_acc_im);
                r_clamp <= r_clamp | clh_pkg::sat_hit(r_acc_re)
                           | clh_pkg::sat_hit(r_acc_im);
                if (!r_neg)             r_p <= r_p - 5'sd1;
                else if (r_p < -5'sd1)  r_p <= r_p + 5'sd1;
                else                    r_p <= '0;
            end
            clh_pkg::S_PEND: begin
                r_pr <= r_ar;
                r_pi <= r_ai;
                r_ar <= '0;
                r_ai <= '0;
                r_p  <= '0;
            end
            clh_pkg::S_SQ1: r_m <= $unsigned(mul_prod);
            clh_pkg::S_SQ2: r_m <= r_m + $unsigned(mul_prod);
            clh_pkg::S_DIV_RE: begin
                if (div_stat.done) begin
                    r_vr    <= div_val;
                    r_clamp <= r_clamp | div_stat.clamp;
                end
            end
            clh_pkg::S_DIV_IM: begin
                if (div_stat.done) begin
                    r_vi    <= div_val;
                    r_clamp <= r_clamp | div_stat.clamp;
                    r_neg   <= 1'b1;
                    r_p     <= lo;
                end
            end
            clh_pkg::S_SUM: begin
                r_fin_re <= clh_pkg::sat_val(fin_sum_re);
                r_fin_im <= clh_pkg::sat_val(fin_sum_im);
                r_fin_st <= (r_clamp | clh_pkg::sat_hit(fin_sum_re)
                             | clh_pkg::sat_hit(fin_sum_im)) ? clh_pkg::ST_SAT : clh_pkg::ST_OK;
            end
            clh_pkg::S_OUT: begin
                if (out_free) begin
                    r_out_re <= r_fin_re;
                    r_out_im <= r_fin_im;
                    r_out_st <= r_fin_st;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'b0, r_out_st, r_out_im, r_out_re};

    // A zero point with negative powers skips all arithmetic.
    `CLH_ASSERT_NEXT(a_pole_short, (r_state == clh_pkg::S_START) && pole, r_state == clh_pkg::S_OUT, "pole did not go straight to output")
    // The divider only finishes while the sequencer waits for it.
    `CLH_ASSERT_NOW(a_div_done, div_stat.done, (r_state == clh_pkg::S_DIV_RE) || (r_state == clh_pkg::S_DIV_IM), "divider finished outside a divide state")
    // The negative-power fold never walks onto power zero.
    `CLH_ASSERT_NOW(a_neg_power, (r_state == clh_pkg::S_ADD) && r_neg, r_p < 0, "negative fold reached a non-negative power")

endmodule

[tb/clh_checker.sv]
// Checker for the Laurent polynomial evaluator: watches all channels, predicts and compares.
module clh_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [103:0] i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [71:0]  i_m_tdata,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [4:0]   i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);

    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [1:0]         st;
    } t_value;

    logic signed [31:0] coef_slot [16];
    logic signed [4:0]  bound_a;
    logic signed [4:0]  bound_b;
    t_value             awaited [$];

    function automatic longint clip(input longint v, inout bit hit);
        if (v > MAXV) begin
            hit = 1'b1;
            return MAXV;
        end
        if (v < MINV) begin
            hit = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    // Exact product, rounded to Q8.24 by adding half an LSB and flooring.
    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 23)) >>> 24;
    endfunction

    // Magnitude n * 2^48 / m, truncated; anything beyond 2^31 is capped at 2^31 + 1.
    function automatic longint unsigned inv_mag(input longint unsigned n,
                                                 input longint unsigned m);
        longint unsigned q;
        longint unsigned r;
        longint unsigned cap;
        cap = 64'd2147483648;
        q = n / m;
        r = n % m;
        if (q > cap) return cap + 1;
        for (int k = 0; k < 48; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= m) begin
                r = r - m;
                q = q | 64'd1;
            end
            if (q > cap) return cap + 1;
        end
        return q;
    endfunction

    function automatic longint coef_for(input int p, input int lo, input int hi);
        if (p < lo || p > hi || p - lo >= 16) return 0;
        return longint'(coef_slot[p - lo]);
    endfunction

    function automatic t_value evaluate(input logic signed [31:0] x_re,
                                        input logic signed [31:0] x_im);
        t_value res;
        bit hit;
        int lo, hi;
        longint xr, xi, pr, pi, nr, ni, tr, ti, vr, vi, re, im;
        longint unsigned ar, ai, mag;
        hit = 1'b0;
        lo = (bound_a < bound_b) ? int'(bound_a) : int'(bound_b);
        hi = (bound_a < bound_b) ? int'(bound_b) : int'(bound_a);
        xr = longint'(x_re);
        xi = longint'(x_im);
        pr = 0; pi = 0; nr = 0; ni = 0;
        if (lo < 0 && xr == 0 && xi == 0) begin
            res.re = 32'sh7fffffff;
            res.im = 32'sh7fffffff;
            res.st = clh_pkg::ST_POLE;
            return res;
        end
        // Positive powers, top down, folded with x.
        for (int p = hi; p >= 1; p--) begin
            tr = clip(coef_for(p, lo, hi) + pr, hit);
            ti = pi;
            re = qmul(xr, tr) - qmul(xi, ti);
            im = qmul(xr, ti) + qmul(xi, tr);
            pr = clip(re, hit);
            pi = clip(im, hit);
        end
        // Negative powers, lowest first, folded with conj(x)/|x|^2.
        if (lo < 0) begin
            ar = (xr < 0) ? longint'(-xr) : longint'(xr);
            ai = (xi < 0) ? longint'(-xi) : longint'(xi);
            mag = ar * ar + ai * ai;
            vr = longint'(inv_mag(ar, mag));
            vi = longint'(inv_mag(ai, mag));
            if (xr < 0) vr = -vr;
            if (xi >= 0) vi = -vi;
            vr = clip(vr, hit);
            vi = clip(vi, hit);
            for (int p = lo; p <= -1; p++) begin
                tr = clip(coef_for(p, lo, hi) + nr, hit);
                ti = ni;
                re = qmul(vr, tr) - qmul(vi, ti);
                im = qmul(vr, ti) + qmul(vi, tr);
                nr = clip(re, hit);
                ni = clip(im, hit);
            end
        end
        res.re = 32'(clip(nr + pr + coef_for(0, lo, hi), hit));
        res.im = 32'(clip(ni + pi, hit));
        res.st = hit ? clh_pkg::ST_SAT : clh_pkg::ST_OK;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_value got;
        t_value want;
        if (!i_rst_n) begin
            bound_a      <= '0;
            bound_b      <= '0;
            o_fail_count <= 0;
            awaited.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == clh_pkg::CFG_LOW) bound_a <= i_cfg_data;
                else bound_b <= i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == clh_pkg::REQ_LOAD)
                    coef_slot[i_s_tdata[3:0]] = i_s_tdata[35:4];
                else
                    awaited.push_back(evaluate(i_s_tdata[67:36], i_s_tdata[99:68]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.re = i_m_tdata[31:0];
                got.im = i_m_tdata[63:32];
                got.st = i_m_tdata[65:64];
                if (awaited.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat re=%h im=%h status=%0d",
                                 got.re, got.im, got.st);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = awaited.pop_front();
                    if (got.re !== want.re || got.im !== want.im || got.st !== want.st
                            || i_m_tdata[71:66] !== 6'd0) begin
                        if (o_fail_count < 10)
                            $display("result mismatch: expected re=%h im=%h status=%0d, %s%h %s%h %s%0d",
                                     want.re, want.im, want.st, "got re=", got.re,
                                     "im=", got.im, "status=", got.st);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = awaited.size();
    end

endmodule

[tb/testbench.sv]
// Top of the testbench: clock, reset, stimulus, the block, the checker and the verdict.
module testbench;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [103:0] i_s_tdata = '0;
    logic         i_s_tuser = clh_pkg::REQ_LOAD;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [71:0]  o_m_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_index = clh_pkg::CFG_LOW;
    logic [4:0]   i_cfg_data = '0;

    int fail_count;
    int pending;
    // When set, neither side idles; hold_req asks the receiver for one long hold-off.
    bit steady = 1'b0;
    bit hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    complex_laurent_horner_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    clh_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Offers one beat and returns once it has been taken. The valid is left high so
    // that a following beat can go out back to back; park_sender lowers it.
    task automatic send(input logic req, input logic [3:0] idx, input logic [31:0] coef,
                        input logic [31:0] xr, input logic [31:0] xi);
        if (!steady && $urandom_range(99) < 8) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {4'd0, xi, xr, coef, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic park_sender();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits for the block to drain; the tail covers a load that is still being absorbed.
    task automatic drain();
        park_sender();
        wait (pending == 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_bounds(input int a, input int b);
        drain();
        write_reg(clh_pkg::CFG_LOW, 5'(a));
        write_reg(clh_pkg::CFG_HIGH, 5'(b));
    endtask

    // Evaluation points: full-range noise, values near the unit circle, tiny ones and zero.
    function automatic logic [31:0] pick_point();
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
            2:       return 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
            3:       return 32'($signed($urandom_range(0, 32'h0180_0000)) - 32'sh00c0_0000);
            4:       return '0;
            default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        if ($urandom_range(3) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endfunction

    // Random mix: roughly one load to two evaluations, every field random.
    task automatic random_items(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(2) == 0)
                send(clh_pkg::REQ_LOAD, 4'($urandom), pick_coef(), $urandom, $urandom);
            else
                send(clh_pkg::REQ_EVAL, 4'($urandom), $urandom, pick_point(), pick_point());
        end
    endtask

    // Receiver: random stalls, a quiet mode, and one long hold-off counted here.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (1500) @(posedge i_clk);
            end else begin
                i_m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 8);
            end
        end
    end

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The table is never cleared, so every slot is written before any evaluation.
        send(clh_pkg::REQ_LOAD, 4'd0, 32'sh7fffffff, '0, '0);
        send(clh_pkg::REQ_LOAD, 4'd1, 32'sh80000000, 32'hffffffff, 32'hffffffff);
        send(clh_pkg::REQ_LOAD, 4'd2, 32'h0100_0000, '0, '0);
        send(clh_pkg::REQ_LOAD, 4'd15, 32'hff00_0000, '0, '0);
        for (int s = 3; s < 15; s++)
            send(clh_pkg::REQ_LOAD, 4'(s), pick_coef(), $urandom, $urandom);

        // Constant term only, then extremes of x with a wide negative range.
        send(clh_pkg::REQ_EVAL, 4'hf, 32'hffffffff, 32'h0100_0000, '0);
        set_bounds(-4, 3);
        send(clh_pkg::REQ_EVAL, '0, '0, '0, '0);
        send(clh_pkg::REQ_EVAL, '0, '0, 32'h7fffffff, 32'h7fffffff);
        send(clh_pkg::REQ_EVAL, '0, '0, 32'h80000000, 32'h80000000);
        send(clh_pkg::REQ_EVAL, '0, '0, 32'h0000_0001, 32'hffff_ffff);
        send(clh_pkg::REQ_EVAL, '0, '0, 32'h0100_0000, 32'h0100_0000);
        send(clh_pkg::REQ_EVAL, '0, '0, 32'h0080_0000, 32'hff80_0000);

        // Bounds given in reverse order, full span beyond the table.
        set_bounds(15, -15);
        send(clh_pkg::REQ_EVAL, '0, '0, 32'h0100_0000, 32'h0000_0000);
        send(clh_pkg::REQ_EVAL, '0, '0, '0, '0);
        random_items(60);

        // Low bound above zero: nothing shifts onto the constant term.
        set_bounds(3, 5);
        send(clh_pkg::REQ_EVAL, '0, '0, '0, '0);
        random_items(90);

        // High bound below zero: positive powers count as zero.
        set_bounds(-6, -2);
        random_items(100);

        // Deepest negative range, the receiver holds off while items keep coming.
        set_bounds(-15, 0);
        hold_req = 1'b1;
        random_items(100);

        // Top positive range with no idling at all on either side.
        set_bounds(0, 15);
        steady = 1'b1;
        random_items(100);
        steady = 1'b0;

        set_bounds(-8, 7);
        random_items(100);
        // Sender waits until every result is back before carrying on.
        drain();
        random_items(60);

        set_bounds(-15, -15);
        random_items(60);

        set_bounds(0, 0);
        random_items(50);

        set_bounds(-1, 1);
        random_items(90);

        drain();
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
